### rtl/psm_pkg.sv
`default_nettype none

package psm_pkg;

    localparam int VALUE_W   = 32;
    localparam int REMOVED_W = 5;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [REMOVED_W-1:0]      removed_count;
        logic                      insert_dropped;
        logic signed [VALUE_W-1:0] smallest;
        logic signed [VALUE_W-1:0] largest;
        logic                      total_is_odd;
    } out_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        logic                      any_match;
        logic                      full;
        logic                      empty;
        logic signed [VALUE_W-1:0] first;
        logic signed [VALUE_W-1:0] last;
    } row_status_t;

endpackage : psm_pkg

`default_nettype wire

### rtl/psm_cell.sv
`default_nettype none

module psm_cell
    import psm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cell_cmd_t                 cmd,
    input  wire logic signed [VALUE_W-1:0] left_value,
    input  wire logic                      left_valid,
    input  wire logic                      left_ge,
    input  wire logic signed [VALUE_W-1:0] right_value,
    input  wire logic                      right_valid,
    output logic signed [VALUE_W-1:0]      value,
    output logic                           valid,
    output logic                           ge,
    output logic                           match
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;

    // An empty cell counts as holding something at least as large as any
    // value, so the ge flags along the row stay monotone.
    assign ge    = !valid_reg || ($signed(value_reg) >= $signed(cmd.value));
    assign match = valid_reg && (value_reg == cmd.value);
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (ge)
                begin
                    if (left_ge)
                    begin
                        value_next = left_value;
                        valid_next = left_valid;
                    end
                    else
                    begin
                        value_next = cmd.value;
                        valid_next = 1'b1;
                    end
                end
            end
            CELL_SHIFT:
            begin
                // The copies of the value form one run; everything from the
                // start of that run moves one place towards the front.
                if (ge)
                begin
                    value_next = right_value;
                    valid_next = right_valid;
                end
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule : psm_cell

`default_nettype wire

### rtl/psm_row.sv
`default_nettype none

module psm_row
    import psm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    output row_status_t    status
);

    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic                      cell_valid [DEPTH];
    logic                      cell_ge    [DEPTH];
    logic                      cell_match [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [VALUE_W-1:0] l_value;
            logic                      l_valid;
            logic                      l_ge;
            logic signed [VALUE_W-1:0] r_value;
            logic                      r_valid;

            if (i == 0)
            begin : g_head
                assign l_value = '0;
                assign l_valid = 1'b0;
                assign l_ge    = 1'b0;
            end
            else
            begin : g_body
                assign l_value = cell_value[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_ge    = cell_ge[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign r_value = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_next
                assign r_value = cell_value[i+1];
                assign r_valid = cell_valid[i+1];
            end

            psm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .left_ge     (l_ge),
                .right_value (r_value),
                .right_valid (r_valid),
                .value       (cell_value[i]),
                .valid       (cell_valid[i]),
                .ge          (cell_ge[i]),
                .match       (cell_match[i])
            );
        end
    endgenerate

    always_comb
    begin
        logic                      any;
        logic signed [VALUE_W-1:0] tail;
        logic                      is_last;
        any  = 1'b0;
        tail = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            any = any | cell_match[k];
            if (k == DEPTH - 1)
            begin
                is_last = cell_valid[k];
            end
            else
            begin
                is_last = cell_valid[k] && !cell_valid[k+1];
            end
            // At most one cell is the last occupied one, so an OR selects it.
            tail = tail | (is_last ? cell_value[k] : '0);
        end
        status.any_match = any;
        status.full      = cell_valid[DEPTH-1];
        status.empty     = !cell_valid[0];
        status.first     = cell_value[0];
        status.last      = tail;
    end

endmodule : psm_row

`default_nettype wire

### rtl/parity_split_sorted_multiset.sv
// Parity-split sorted multiset.
// Input channel in_valid/in_ready/in_data carries an action (insert or
// remove-all) and a signed 32-bit value; bit 0 of the value picks the even
// or the odd partition. Each partition is a row of DEPTH cells kept in
// ascending order. Output channel out_valid/out_ready/out_data returns one
// result per item: copies removed, a dropped-insert flag, the smallest and
// largest stored values and the parity of the total count.
// An insert moves the whole row in a single ST_INSERT step; a remove deletes
// the copies one at a time in ST_REMOVE (at most DEPTH of them) until a step
// finds no copy left. Either then waits in ST_DONE, and its result is loaded
// into the output register once that register is free. The next item is
// taken once the result has been loaded into the output register, which
// holds it while the receiver stalls; a second result waits in the control
// logic until that register is free.
// Reset empties both partitions at once (no clearing pass) and drops any
// pending result.
`default_nettype none

module parity_split_sorted_multiset
    import psm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INSERT = 4'b0010,
        ST_REMOVE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic signed [VALUE_W-1:0] item_value_reg;
    logic                      item_odd_reg;
    logic [CNT_W-1:0]          removed_reg;
    logic [CNT_W-1:0]          removed_next;
    logic                      dropped_reg;
    logic                      dropped_next;
    logic [CNT_W-1:0]          even_count_reg;
    logic [CNT_W-1:0]          even_count_next;
    logic [CNT_W-1:0]          odd_count_reg;
    logic [CNT_W-1:0]          odd_count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_item_t                 out_data_reg;
    out_item_t                 result;

    cell_cmd_t                 even_cmd;
    cell_cmd_t                 odd_cmd;
    row_status_t               even_st;
    row_status_t               odd_st;
    row_status_t               sel_st;
    logic                      load_out;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign sel_st    = item_odd_reg ? odd_st : even_st;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        even_cmd.value = item_value_reg;
        odd_cmd.value  = item_value_reg;
        even_cmd.op    = CELL_HOLD;
        odd_cmd.op     = CELL_HOLD;
        if (state_reg == ST_INSERT && !sel_st.full)
        begin
            if (item_odd_reg)
            begin
                odd_cmd.op = CELL_INSERT;
            end
            else
            begin
                even_cmd.op = CELL_INSERT;
            end
        end
        else if (state_reg == ST_REMOVE && sel_st.any_match)
        begin
            if (item_odd_reg)
            begin
                odd_cmd.op = CELL_SHIFT;
            end
            else
            begin
                even_cmd.op = CELL_SHIFT;
            end
        end
    end

    psm_row #(.DEPTH(DEPTH)) u_even_row (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (even_cmd),
        .status (even_st)
    );

    psm_row #(.DEPTH(DEPTH)) u_odd_row (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (odd_cmd),
        .status (odd_st)
    );

    always_comb
    begin
        lo = VALUE_MAX;
        hi = VALUE_MIN;
        if (!even_st.empty)
        begin
            lo = even_st.first;
            hi = even_st.last;
        end
        if (!odd_st.empty && ($signed(odd_st.first) < $signed(lo)))
        begin
            lo = odd_st.first;
        end
        if (!odd_st.empty && ($signed(odd_st.last) > $signed(hi)))
        begin
            hi = odd_st.last;
        end
        result.removed_count  = REMOVED_W'(removed_reg);
        result.insert_dropped = dropped_reg;
        result.smallest       = lo;
        result.largest        = hi;
        result.total_is_odd   = even_count_reg[0] ^ odd_count_reg[0];
    end

    always_comb
    begin
        state_next      = state_reg;
        removed_next    = removed_reg;
        dropped_next    = dropped_reg;
        even_count_next = even_count_reg;
        odd_count_next  = odd_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    removed_next = '0;
                    dropped_next = 1'b0;
                    state_next   = in_data.action ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                dropped_next = sel_st.full;
                if (!sel_st.full)
                begin
                    if (item_odd_reg)
                    begin
                        odd_count_next = odd_count_reg + 1'b1;
                    end
                    else
                    begin
                        even_count_next = even_count_reg + 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_REMOVE:
            begin
                if (sel_st.any_match)
                begin
                    removed_next = removed_reg + 1'b1;
                    if (item_odd_reg)
                    begin
                        odd_count_next = odd_count_reg - 1'b1;
                    end
                    else
                    begin
                        even_count_next = even_count_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            removed_reg    <= '0;
            dropped_reg    <= 1'b0;
            even_count_reg <= '0;
            odd_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            removed_reg    <= removed_next;
            dropped_reg    <= dropped_next;
            even_count_reg <= even_count_next;
            odd_count_reg  <= odd_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_value_reg <= in_data.value;
            item_odd_reg   <= in_data.value[0];
        end
        if (load_out)
        begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register lost its one-hot code");

    a_even_full: assert property (@(posedge clk) disable iff (!rst_n)
        even_st.full == (even_count_reg == CNT_W'(DEPTH)))
        else $error("even row occupancy disagrees with its count");

    a_odd_full: assert property (@(posedge clk) disable iff (!rst_n)
        odd_st.full == (odd_count_reg == CNT_W'(DEPTH)))
        else $error("odd row occupancy disagrees with its count");

    a_even_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT && !item_odd_reg && !even_st.full)
        |=> even_count_reg == $past(even_count_reg) + 1'b1)
        else $error("insert into even row did not add one entry");

    a_removed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        removed_reg <= CNT_W'(DEPTH))
        else $error("removal count exceeds row depth");
`endif

endmodule : parity_split_sorted_multiset

`default_nettype wire

### verif/parity_split_sorted_multiset_tb.sv
`timescale 1ns / 1ps

module parity_split_sorted_multiset_tb;
    import psm_pkg::*;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Predicted contents: index 0 holds the even partition, index 1 the odd one.
    logic signed [VALUE_W-1:0] stored_rows [2][DEPTH];
    int unsigned               row_len [2];

    out_item_t expected_results [$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_request   = 0;
    int        hold_left      = 0;
    int        quiet_cycles   = 0;

    parity_split_sorted_multiset #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    function automatic out_item_t apply_operation(input in_item_t item);
        out_item_t                 res;
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        int unsigned               p;
        int unsigned               n;
        int unsigned               pos;
        int unsigned               k;
        int unsigned               gone;
        v    = item.value;
        p    = 32'(v[0]);
        n    = row_len[p];
        res  = '0;
        gone = 0;
        if (item.action == ACT_INSERT)
        begin
            if (n >= DEPTH)
                res.insert_dropped = 1'b1;
            else
            begin
                pos = 0;
                while (pos < n && stored_rows[p][pos] < v)
                    pos++;
                for (int j = n; j > pos; j--)
                    stored_rows[p][j] = stored_rows[p][j-1];
                stored_rows[p][pos] = v;
                row_len[p] = n + 1;
            end
        end
        else
        begin
            k = 0;
            for (int i = 0; i < n; i++)
            begin
                if (stored_rows[p][i] != v)
                begin
                    stored_rows[p][k] = stored_rows[p][i];
                    k++;
                end
                else
                    gone++;
            end
            row_len[p] = k;
        end
        lo = VALUE_MAX;
        hi = VALUE_MIN;
        for (int r = 0; r < 2; r++)
        begin
            if (row_len[r] > 0)
            begin
                if (stored_rows[r][0] < lo)
                    lo = stored_rows[r][0];
                if (stored_rows[r][row_len[r]-1] > hi)
                    hi = stored_rows[r][row_len[r]-1];
            end
        end
        res.removed_count = gone[REMOVED_W-1:0];
        res.smallest      = lo;
        res.largest       = hi;
        res.total_is_odd  = 1'((row_len[0] + row_len[1]) % 2);
        return res;
    endfunction

    function automatic in_item_t make_item(input logic act, input logic signed [VALUE_W-1:0] v);
        in_item_t item;
        item.action = act;
        item.value  = v;
        return item;
    endfunction

    // Mostly a small pool of values so that duplicates pile up and partitions
    // fill; the rest spread over the whole range and its edges.
    function automatic in_item_t random_item();
        logic signed [VALUE_W-1:0] v;
        logic                      act;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = $signed($urandom_range(23)) - 12;
            6, 7:             v = $urandom();
            8:                v = VALUE_MIN + $signed($urandom_range(3));
            default:          v = VALUE_MAX - $signed($urandom_range(3));
        endcase
        act = ($urandom_range(99) < 62) ? ACT_INSERT : ACT_REMOVE;
        return make_item(act, v);
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens,
    // leaving valid high so the next item can follow without a gap.
    task automatic send_item(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The result is checked before the prediction of an item accepted on the
    // same edge is queued, since it always belongs to an earlier transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: removed=%0d dropped=%0b min=%0d max=%0d odd=%0b",
                                 out_data.removed_count, out_data.insert_dropped,
                                 $signed(out_data.smallest), $signed(out_data.largest),
                                 out_data.total_is_odd);
                end
                else
                begin
                    automatic out_item_t exp_res = expected_results.pop_front();
                    if (out_data.removed_count !== exp_res.removed_count ||
                        out_data.insert_dropped !== exp_res.insert_dropped ||
                        out_data.smallest !== exp_res.smallest ||
                        out_data.largest !== exp_res.largest ||
                        out_data.total_is_odd !== exp_res.total_is_odd)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("mismatch exp: removed=%0d dropped=%0b min=%0d max=%0d odd=%0b",
                                     exp_res.removed_count, exp_res.insert_dropped,
                                     $signed(exp_res.smallest), $signed(exp_res.largest),
                                     exp_res.total_is_odd);
                            $display("         got: removed=%0d dropped=%0b min=%0d max=%0d odd=%0b",
                                     out_data.removed_count, out_data.insert_dropped,
                                     $signed(out_data.smallest), $signed(out_data.largest),
                                     out_data.total_is_odd);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_operation(in_data));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("parity_split_sorted_multiset test failed");
            $finish;
        end
    end

    task automatic test_extreme_values();
        send_item(make_item(ACT_INSERT, VALUE_MIN));
        send_item(make_item(ACT_INSERT, VALUE_MAX));
        send_item(make_item(ACT_INSERT, -32'sd1));
        send_item(make_item(ACT_INSERT, VALUE_MIN));
        send_item(make_item(ACT_REMOVE, VALUE_MIN));
        // Removing a value that is not stored must leave everything alone.
        send_item(make_item(ACT_REMOVE, 32'sd3));
        send_item(make_item(ACT_REMOVE, VALUE_MAX));
    endtask

    task automatic test_full_partition();
        for (int i = 0; i < DEPTH; i++)
            send_item(make_item(ACT_INSERT, 32'sd4));
        send_item(make_item(ACT_INSERT, 32'sd6));
        send_item(make_item(ACT_REMOVE, 32'sd4));
        send_item(make_item(ACT_REMOVE, -32'sd1));
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
            send_item(random_item());
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 150);
        run_random_phase(50, 0, 150);
        run_random_phase(0, 50, 150);
        run_random_phase(32, 32, 150);
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // output register and the pending result fill and the input must stall.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        for (int i = 0; i < 60; i++)
            send_item(random_item());
        wait_for_results();
    endtask

    initial
    begin
        row_len[0] = 0;
        row_len[1] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_values();
        test_full_partition();
        wait_for_results();
        test_random_traffic();
        test_output_backpressure();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("parity_split_sorted_multiset test passed");
        else
            $display("parity_split_sorted_multiset test failed");
        $finish;
    end

endmodule

### files.f
rtl/psm_pkg.sv
rtl/psm_cell.sv
rtl/psm_row.sv
rtl/parity_split_sorted_multiset.sv
verif/parity_split_sorted_multiset_tb.sv
